>>> rtl/core/bgc_pkg.sv
package bgc_pkg;

  localparam int unsigned DEB_W   = 8;
  localparam int unsigned TICK_W  = 20;
  localparam int unsigned CLICK_W = 3;
  localparam int unsigned CFG_W   = 20;
  localparam int unsigned IDX_W   = 3;

  localparam logic [DEB_W-1:0]  DEBOUNCE_RST  = 8'd50;
  localparam logic [TICK_W-1:0] LONG_RST      = 20'd1000;
  localparam logic [TICK_W-1:0] VERY_LONG_RST = 20'd3000;
  localparam logic [TICK_W-1:0] RESET_RST     = 20'd10000;
  localparam logic [TICK_W-1:0] CLICK_GAP_RST = 20'd300;

  typedef enum logic {
    ACT_TICK  = 1'b0,
    ACT_CLEAR = 1'b1
  } action_e;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_SINGLE    = 3'd1,
    EV_DOUBLE    = 3'd2,
    EV_TRIPLE    = 3'd3,
    EV_LONG      = 3'd4,
    EV_VERY_LONG = 3'd5,
    EV_RESET     = 3'd6
  } event_e;

  typedef enum logic [IDX_W-1:0] {
    CFG_DEBOUNCE    = 3'd0,
    CFG_LONG        = 3'd1,
    CFG_VERY_LONG   = 3'd2,
    CFG_RESET_PRESS = 3'd3,
    CFG_CLICK_GAP   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    action_e action;
    logic    raw_level;
  } in_item_t;

  typedef struct packed {
    event_e              event_code;
    logic                is_down;
    logic [TICK_W-1:0]   held_ms;
  } out_item_t;

endpackage

>>> rtl/core/bgc_stream_if.sv
interface bgc_stream_if #(
  parameter type data_t = logic
);
  logic  valid;
  logic  ready;
  data_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

>>> rtl/core/button_gesture_classifier_top.sv
// Channel   Direction  Payload                              Handshake
// in_i      sink       action, raw_level                    valid / ready
// out_o     source     event_code, is_down, held_ms         valid / ready
// cfg       write      cfg_we_i, cfg_idx_i, cfg_data_i      write enable only
//
// An item is taken into an input register, classified combinationally and the
// result lands in an output register; one item per cycle while the output is not stalled.
// Reset restores the default thresholds and the released, idle gesture state.
// A stalled output register holds the input stage; the input register still
// takes a transaction whenever its content moves on in the same cycle.
module button_gesture_classifier_top
  import bgc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [IDX_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  bgc_stream_if.sink         in_i,
  bgc_stream_if.source       out_o
);

  logic [DEB_W-1:0]   debounce_ms_q;
  logic [TICK_W-1:0]  long_ms_q, very_long_ms_q, reset_ms_q, click_gap_ms_q;

  logic               in_valid_q;
  in_item_t           in_q;
  logic               out_valid_q;
  out_item_t          out_q, out_d;
  logic               advance;

  logic               stable_q, stable_d;
  logic [DEB_W-1:0]   deb_q, deb_d, deb_inc;
  logic [TICK_W-1:0]  press_q, press_d;
  logic [TICK_W-1:0]  gap_q, gap_d, gap_inc;
  logic [CLICK_W-1:0] clicks_q, clicks_d;
  logic               long_f_q, long_f_d;
  logic               vlong_f_q, vlong_f_d;
  logic               reset_f_q, reset_f_d;
  logic               changed;
  event_e             ev;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      debounce_ms_q  <= DEBOUNCE_RST;
      long_ms_q      <= LONG_RST;
      very_long_ms_q <= VERY_LONG_RST;
      reset_ms_q     <= RESET_RST;
      click_gap_ms_q <= CLICK_GAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_DEBOUNCE:    debounce_ms_q  <= cfg_data_i[DEB_W-1:0];
        CFG_LONG:        long_ms_q      <= cfg_data_i[TICK_W-1:0];
        CFG_VERY_LONG:   very_long_ms_q <= cfg_data_i[TICK_W-1:0];
        CFG_RESET_PRESS: reset_ms_q     <= cfg_data_i[TICK_W-1:0];
        CFG_CLICK_GAP:   click_gap_ms_q <= cfg_data_i[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance     = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready  = !in_valid_q || advance;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= (in_i.valid && in_i.ready) || (in_valid_q && !advance);
      out_valid_q <= advance || (out_valid_q && !out_o.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.data;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  always_comb begin
    stable_d  = stable_q;
    deb_d     = deb_q;
    press_d   = press_q;
    gap_d     = gap_q;
    clicks_d  = clicks_q;
    long_f_d  = long_f_q;
    vlong_f_d = vlong_f_q;
    reset_f_d = reset_f_q;
    changed   = 1'b0;
    ev        = EV_NONE;
    deb_inc   = (deb_q != '1) ? deb_q + 1'b1 : deb_q;
    gap_inc   = (gap_q != '1) ? gap_q + 1'b1 : gap_q;

    if (in_q.action == ACT_CLEAR) begin
      press_d   = '0;
      gap_d     = '0;
      clicks_d  = '0;
      long_f_d  = 1'b0;
      vlong_f_d = 1'b0;
      reset_f_d = 1'b0;
    end else begin
      if (in_q.raw_level != stable_q) begin
        if (deb_inc >= debounce_ms_q) begin
          stable_d = in_q.raw_level;
          deb_d    = '0;
          changed  = 1'b1;
        end else begin
          deb_d = deb_inc;
        end
      end else begin
        deb_d = '0;
      end

      if (changed && !stable_d) begin
        press_d   = '0;
        long_f_d  = 1'b0;
        vlong_f_d = 1'b0;
        reset_f_d = 1'b0;
        gap_d     = gap_inc;
      end else if (changed) begin
        press_d = '0;
        // Only a press that fired no hold event counts as a click.
        if (!long_f_q && !vlong_f_q && !reset_f_q) begin
          clicks_d = (clicks_q != '1) ? clicks_q + 1'b1 : clicks_q;
          gap_d    = '0;
        end else begin
          gap_d = gap_inc;
        end
      end else begin
        if (!stable_q && press_q != '1) begin
          press_d = press_q + 1'b1;
        end
        gap_d = gap_inc;
      end

      if (!stable_d) begin
        if (press_d >= reset_ms_q && !reset_f_d) begin
          reset_f_d = 1'b1;
          ev        = EV_RESET;
        end else if (press_d >= very_long_ms_q && !vlong_f_d) begin
          vlong_f_d = 1'b1;
          ev        = EV_VERY_LONG;
        end else if (press_d >= long_ms_q && !long_f_d) begin
          long_f_d = 1'b1;
          ev       = EV_LONG;
        end
      end else if (clicks_d != '0 && gap_d > click_gap_ms_q) begin
        case (clicks_d)
          3'd2:    ev = EV_DOUBLE;
          3'd3:    ev = EV_TRIPLE;
          default: ev = EV_SINGLE;
        endcase
        clicks_d = '0;
      end
    end

    out_d.event_code = ev;
    out_d.is_down    = !stable_d;
    out_d.held_ms    = stable_d ? '0 : press_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q  <= 1'b1;
      deb_q     <= '0;
      press_q   <= '0;
      gap_q     <= '0;
      clicks_q  <= '0;
      long_f_q  <= 1'b0;
      vlong_f_q <= 1'b0;
      reset_f_q <= 1'b0;
    end else if (advance) begin
      stable_q  <= stable_d;
      deb_q     <= deb_d;
      press_q   <= press_d;
      gap_q     <= gap_d;
      clicks_q  <= clicks_d;
      long_f_q  <= long_f_d;
      vlong_f_q <= vlong_f_d;
      reset_f_q <= reset_f_d;
    end
  end

  a_released_no_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.is_down |-> out_q.held_ms == '0)
    else $error("released result carries a press duration");

  a_hold_event_down: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.event_code == EV_LONG || out_q.event_code == EV_VERY_LONG ||
                    out_q.event_code == EV_RESET) |-> out_q.is_down)
    else $error("hold event reported while released");

  a_click_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.event_code == EV_SINGLE || out_q.event_code == EV_DOUBLE ||
                    out_q.event_code == EV_TRIPLE) |-> !out_q.is_down)
    else $error("click reported while held");

  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_q.action == ACT_CLEAR |=> out_q.event_code == EV_NONE && clicks_q == '0)
    else $error("clear transaction produced an event or left clicks pending");

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
  import bgc_pkg::*;

  localparam logic [TICK_W-1:0] TICK_MAX = '1;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we;
  logic [IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0] cfg_data;

  bgc_stream_if #(.data_t(in_item_t))  in_if ();
  bgc_stream_if #(.data_t(out_item_t)) out_if ();

  button_gesture_classifier_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #6 clk_i = ~clk_i;

  // Thresholds as the block should hold them.
  logic [DEB_W-1:0]  cfg_debounce;
  logic [TICK_W-1:0] cfg_long;
  logic [TICK_W-1:0] cfg_vlong;
  logic [TICK_W-1:0] cfg_reset_press;
  logic [TICK_W-1:0] cfg_gap;

  // Gesture state of the classifier as predicted.
  logic                db_level;
  logic [DEB_W-1:0]    db_count;
  logic [TICK_W-1:0]   press_len;
  logic [TICK_W-1:0]   gap_len;
  logic [CLICK_W-1:0]  click_cnt;
  logic                long_seen;
  logic                vlong_seen;
  logic                rst_seen;

  in_item_t    tick_q[$];
  out_item_t   gesture_q[$];
  logic        in_taken = 1'b0;
  logic        quiet = 1'b0;
  int unsigned queued = 0;
  int unsigned sent = 0;
  int unsigned checked = 0;
  int unsigned errors = 0;
  int unsigned settings = 0;
  int unsigned ev_tally [8] = '{default: 0};

  function automatic out_item_t classify_tick(input in_item_t it);
    out_item_t res;
    event_e    ev;
    logic      accepted;
    ev = EV_NONE;
    accepted = 1'b0;
    if (it.action == ACT_CLEAR) begin
      click_cnt  = '0;
      gap_len    = '0;
      press_len  = '0;
      long_seen  = 1'b0;
      vlong_seen = 1'b0;
      rst_seen   = 1'b0;
    end else begin
      if (it.raw_level != db_level) begin
        if (db_count != '1) db_count = db_count + 1'b1;
        if (db_count >= cfg_debounce) begin
          db_level = it.raw_level;
          db_count = '0;
          accepted = 1'b1;
        end
      end else begin
        db_count = '0;
      end

      if (accepted && !db_level) begin
        press_len  = '0;
        long_seen  = 1'b0;
        vlong_seen = 1'b0;
        rst_seen   = 1'b0;
        if (gap_len != TICK_MAX) gap_len = gap_len + 1'b1;
      end else if (accepted) begin
        press_len = '0;
        // Only a press that fired none of the hold events counts as a click.
        if (!long_seen && !vlong_seen && !rst_seen) begin
          if (click_cnt != '1) click_cnt = click_cnt + 1'b1;
          gap_len = '0;
        end else if (gap_len != TICK_MAX) begin
          gap_len = gap_len + 1'b1;
        end
      end else begin
        if (!db_level && press_len != TICK_MAX) press_len = press_len + 1'b1;
        if (gap_len != TICK_MAX) gap_len = gap_len + 1'b1;
      end

      if (!db_level) begin
        if (press_len >= cfg_reset_press && !rst_seen) begin
          rst_seen = 1'b1;
          ev = EV_RESET;
        end else if (press_len >= cfg_vlong && !vlong_seen) begin
          vlong_seen = 1'b1;
          ev = EV_VERY_LONG;
        end else if (press_len >= cfg_long && !long_seen) begin
          long_seen = 1'b1;
          ev = EV_LONG;
        end
      end
      if (ev == EV_NONE && db_level && click_cnt != '0 && gap_len > cfg_gap) begin
        case (click_cnt)
          3'd2: ev = EV_DOUBLE;
          3'd3: ev = EV_TRIPLE;
          default: ev = EV_SINGLE;
        endcase
        click_cnt = '0;
      end
    end
    res.event_code = ev;
    res.is_down    = !db_level;
    res.held_ms    = db_level ? '0 : press_len;
    return res;
  endfunction

  task automatic push_item(input action_e act, input logic lvl);
    in_item_t it;
    it.action    = act;
    it.raw_level = lvl;
    tick_q.push_back(it);
    queued++;
  endtask

  task automatic push_run(input logic lvl, input int unsigned n);
    repeat (n) push_item(ACT_TICK, lvl);
  endtask

  // Waits until every queued tick has gone in and every result has come back, else flags the missing results.
  task automatic drain();
    int unsigned waited;
    waited = 0;
    do begin
      @(posedge clk_i);
      #1;
    end while (tick_q.size() != 0 || in_if.valid);
    while (gesture_q.size() != 0 && waited < 2000) begin
      @(posedge clk_i);
      #1;
      waited++;
    end
    if (gesture_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, gesture_q.size());
      errors++;
      gesture_q.delete();
    end
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
  endtask

  task automatic apply_cfg(input logic [DEB_W-1:0] deb, input logic [TICK_W-1:0] lng,
                           input logic [TICK_W-1:0] vlng, input logic [TICK_W-1:0] rstp,
                           input logic [TICK_W-1:0] gap);
    write_reg(CFG_DEBOUNCE, CFG_W'(deb));
    write_reg(CFG_LONG, lng);
    write_reg(CFG_VERY_LONG, vlng);
    write_reg(CFG_RESET_PRESS, rstp);
    write_reg(CFG_CLICK_GAP, gap);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    cfg_debounce    = deb;
    cfg_long        = lng;
    cfg_vlong       = vlng;
    cfg_reset_press = rstp;
    cfg_gap         = gap;
    settings++;
    @(posedge clk_i);
    #1;
  endtask

  // Mostly whole click and hold gestures, with clears, short glitches and
  // contact bounce mixed in. Run lengths are capped so huge thresholds stay cheap.
  task automatic add_gestures(input int unsigned target);
    int unsigned start;
    int unsigned n_clicks;
    int unsigned hold;
    int unsigned pause;
    int unsigned deb_len;
    int unsigned r;
    start = queued;
    deb_len = (cfg_debounce == '0) ? 1 : cfg_debounce;
    while (queued - start < target) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        push_item(ACT_CLEAR, 1'($urandom_range(0, 1)));
      end else if (r < 18) begin
        push_run(1'($urandom_range(0, 1)), $urandom_range(1, deb_len));
      end else begin
        n_clicks = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 8) : $urandom_range(1, 4);
        repeat (n_clicks) begin
          hold = ($urandom_range(0, 2) != 0) ? $urandom_range(0, cfg_long)
                                             : $urandom_range(0, cfg_reset_press + 3);
          if (hold > 100) hold = $urandom_range(0, 100);
          if ($urandom_range(0, 7) == 0) begin
            push_run(1'b0, $urandom_range(1, deb_len));
            push_item(ACT_TICK, 1'b1);
          end
          push_run(1'b0, deb_len + hold);
          pause = ($urandom_range(0, 3) == 0) ? cfg_gap + 1 : $urandom_range(0, cfg_gap);
          if (pause > 100) pause = $urandom_range(0, 100);
          push_run(1'b1, deb_len + pause);
        end
        pause = cfg_gap + 2;
        if (pause > 100) pause = $urandom_range(0, 100);
        push_run(1'b1, pause);
      end
    end
  endtask

  // Driver: a new transaction is offered once the previous one was taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!in_if.valid || in_taken) begin
        if (tick_q.size() != 0 && (quiet || $urandom_range(0, 99) >= 14)) begin
          in_if.valid <= 1'b1;
          in_if.data  <= tick_q.pop_front();
        end else begin
          in_if.valid <= 1'b0;
        end
      end
      out_if.ready <= quiet || ($urandom_range(0, 99) >= 14);
    end
  end

  // Monitor: checks each result, then predicts for the input just taken.
  always @(posedge clk_i) begin
    out_item_t want;
    out_item_t got;
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        checked++;
        ev_tally[got.event_code]++;
        if (gesture_q.size() == 0) begin
          errors++;
          if (errors < 40)
            $display("%0t: unexpected result: event %0d down %0b held %0d", $time,
                     got.event_code, got.is_down, got.held_ms);
        end else begin
          want = gesture_q.pop_front();
          if (got.event_code !== want.event_code) begin
            errors++;
            if (errors < 40)
              $display("%0t: event_code expected %0d actual %0d", $time,
                       want.event_code, got.event_code);
          end
          if (got.is_down !== want.is_down) begin
            errors++;
            if (errors < 40)
              $display("%0t: is_down expected %0b actual %0b", $time,
                       want.is_down, got.is_down);
          end
          if (got.held_ms !== want.held_ms) begin
            errors++;
            if (errors < 40)
              $display("%0t: held_ms expected %0d actual %0d", $time,
                       want.held_ms, got.held_ms);
          end
        end
      end
      if (in_if.valid && in_if.ready) begin
        gesture_q.push_back(classify_tick(in_if.data));
        sent++;
      end
    end
    in_taken <= rst_ni && in_if.valid && in_if.ready;
  end

  initial begin
    int unsigned k;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    out_if.ready = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = '0;
    cfg_data     = '0;
    rst_ni       = 1'b0;

    cfg_debounce    = DEBOUNCE_RST;
    cfg_long        = LONG_RST;
    cfg_vlong       = VERY_LONG_RST;
    cfg_reset_press = RESET_RST;
    cfg_gap         = CLICK_GAP_RST;
    db_level   = 1'b1;
    db_count   = '0;
    press_len  = '0;
    gap_len    = '0;
    click_cnt  = '0;
    long_seen  = 1'b0;
    vlong_seen = 1'b0;
    rst_seen   = 1'b0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    #1;

    // Default thresholds: a short bounce is never accepted.
    push_item(ACT_CLEAR, 1'b1);
    push_item(ACT_TICK, 1'b0);
    push_item(ACT_TICK, 1'b0);
    push_item(ACT_TICK, 1'b1);
    push_item(ACT_CLEAR, 1'b0);
    drain();

    // All thresholds zero: reset, very long and long fire on successive ticks.
    apply_cfg(8'd0, '0, '0, '0, '0);
    push_run(1'b0, 4);
    push_item(ACT_TICK, 1'b1);
    drain();

    // Single click, then a double click.
    apply_cfg(8'd1, 20'd3, 20'd5, 20'd7, 20'd2);
    push_item(ACT_TICK, 1'b0);
    push_run(1'b1, 4);
    push_item(ACT_TICK, 1'b0);
    push_item(ACT_TICK, 1'b1);
    push_item(ACT_TICK, 1'b0);
    push_run(1'b1, 5);
    drain();

    apply_cfg(8'd2, 20'd4, 20'd8, 20'd12, 20'd3);
    add_gestures(100);
    drain();

    // Random small thresholds, in any order, so the event priority is exercised.
    for (k = 0; k < 2; k++) begin
      apply_cfg(8'($urandom_range(0, 3)), 20'($urandom_range(0, 12)),
                20'($urandom_range(0, 12)), 20'($urandom_range(0, 12)),
                20'($urandom_range(0, 8)));
      add_gestures(60);
      drain();
    end

    apply_cfg(8'd6, 20'd12, 20'd20, 20'd28, 20'd9);
    add_gestures(80);
    drain();

    // Largest thresholds: clicks pile up unreported until the click counter
    // saturates, and a short hold fires none of the hold events.
    quiet = 1'b1;
    apply_cfg(8'd0, TICK_MAX, TICK_MAX, TICK_MAX, TICK_MAX);
    repeat (8) begin
      push_item(ACT_TICK, 1'b0);
      push_item(ACT_TICK, 1'b1);
    end
    push_run(1'b0, 20);
    push_run(1'b1, 4);
    drain();

    // Equal long and very long thresholds, zero gap; the saturated clicks
    // left pending above are reported first.
    apply_cfg(8'd1, 20'd5, 20'd5, 20'd9, 20'd0);
    add_gestures(80);
    drain();
    quiet = 1'b0;

    repeat (4) @(posedge clk_i);
    $display("Sent %0d button transactions under %0d threshold settings; %0d results checked.",
             sent, settings, checked);
    $display("Events: single %0d, double %0d, triple %0d, long %0d, very long %0d, reset %0d.",
             ev_tally[EV_SINGLE], ev_tally[EV_DOUBLE], ev_tally[EV_TRIPLE],
             ev_tally[EV_LONG], ev_tally[EV_VERY_LONG], ev_tally[EV_RESET]);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(64'd60_000_000);
    $display("Timed out waiting for the classifier.");
    $display("Test completed with failures");
    $finish;
  end

endmodule

>>> sim.f
rtl/core/bgc_pkg.sv
rtl/core/bgc_stream_if.sv
rtl/core/button_gesture_classifier_top.sv
tb/tb.sv
